>>> sv/htwd_pkg.sv
// Shared types and constants of the Huffman tree-walk decoder.
`default_nettype none

package htwd_pkg;

  localparam int TREE_NODES_DEF  = 128;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 7;
  localparam int CHILD_W = 9;
  localparam int SYM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 20;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_DECODE,
    KIND_START
  } htwd_kind_e;

  typedef struct packed {
    htwd_kind_e                 kind;
    logic [IDX_W-1:0]           node_index;
    logic signed [CHILD_W-1:0]  zero_branch;
    logic signed [CHILD_W-1:0]  one_branch;
    logic [BYTE_W-1:0]          data_byte;
  } htwd_cmd_t;

  localparam int CMD_W = $bits(htwd_cmd_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } htwd_state_e;

endpackage

`default_nettype wire

>>> sv/htwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htwd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/htwd_fifo.sv
// Small register queue between the request front end and the tree walker.
`default_nettype none

module htwd_fifo #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 2   // power of two
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             full_o,
  output      logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FILL_W'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/htwd_front.sv
// Request front end: unpack, classify and filter incoming requests.
`default_nettype none

module htwd_front #(
  parameter int TREE_NODES = 128
) (
  input  wire logic                              s_tvalid_i,
  output      logic                              s_tready_o,
  input  wire logic [htwd_pkg::IN_DATA_W-1:0]    s_tdata_i,
  input  wire logic [htwd_pkg::OP_W-1:0]         s_tuser_i,
  input  wire logic                              q_full_i,
  output      logic                              q_push_o,
  output      htwd_pkg::htwd_cmd_t               q_cmd_o
);

  import htwd_pkg::*;

  localparam int IDX_LO   = 0;
  localparam int LEFT_LO  = IDX_LO + IDX_W;
  localparam int RIGHT_LO = LEFT_LO + CHILD_W;
  localparam int BYTE_LO  = RIGHT_LO + CHILD_W;
  localparam int LIM_W    = IDX_W + 1;
  localparam logic [LIM_W-1:0] NODE_LIMIT = LIM_W'(TREE_NODES);

  logic keep;
  logic accept;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && !q_full_i;

  always_comb begin
    q_cmd_o.kind        = KIND_LOAD;
    q_cmd_o.node_index  = s_tdata_i[IDX_LO +: IDX_W];
    q_cmd_o.zero_branch = s_tdata_i[LEFT_LO +: CHILD_W];
    q_cmd_o.one_branch  = s_tdata_i[RIGHT_LO +: CHILD_W];
    q_cmd_o.data_byte   = s_tdata_i[BYTE_LO +: BYTE_W];
    keep                = 1'b0;
    case (s_tuser_i)
      OP_LOAD: begin
        // drop loads that name no node of the table
        q_cmd_o.kind = KIND_LOAD;
        keep         = ({1'b0, q_cmd_o.node_index} < NODE_LIMIT);
      end
      OP_DECODE: begin
        q_cmd_o.kind = KIND_DECODE;
        keep         = 1'b1;
      end
      OP_START: begin
        q_cmd_o.kind = KIND_START;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && keep;

endmodule

`default_nettype wire

>>> sv/htwd_back.sv
// Tree walker: executes queued commands, one tree step per cycle unless a stalled output holds it.
`default_nettype none

module htwd_back #(
  parameter int TREE_NODES = 128,
  parameter int AW         = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [htwd_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  wire logic                            q_empty_i,
  input  wire htwd_pkg::htwd_cmd_t             q_cmd_i,
  output      logic                            q_pop_o,
  output      logic                            ram_we_o,
  output      logic [AW-1:0]                   ram_waddr_o,
  output      logic [2*htwd_pkg::CHILD_W-1:0]  ram_wdata_o,
  output      logic [AW-1:0]                   ram_raddr_o,
  input  wire logic [2*htwd_pkg::CHILD_W-1:0]  ram_rdata_i,
  output      logic                            m_tvalid_o,
  input  wire logic                            m_tready_i,
  output      logic [htwd_pkg::SYM_W-1:0]      m_symbol_o,
  output      logic                            m_last_o,
  output      logic                            m_done_o
);

  import htwd_pkg::*;

  localparam int BIT_CNT_W = $clog2(BYTE_W);
  localparam int MAG_W     = CHILD_W - 1;
  localparam logic [MAG_W-1:0] NODE_LIMIT = MAG_W'(TREE_NODES);

  htwd_state_e state_q, state_d;

  logic [AW-1:0]        node_q, node_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     total_q;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic [BIT_CNT_W-1:0] bits_q, bits_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0]     pend_sym_q, pend_sym_d;
  logic                 pend_done_q, pend_done_d;

  logic                 out_valid_q;
  logic [SYM_W-1:0]     out_sym_q;
  logic                 out_last_q;
  logic                 out_done_q;
  logic                 out_push;
  logic                 out_last_n;
  logic                 out_free;

  logic [CHILD_W-1:0]   child;
  logic [CHILD_W-1:0]   child_neg;
  logic                 child_pos;
  logic                 leaf;
  logic [SYM_W-1:0]     sym;
  logic [CNT_W-1:0]     cnt_inc;
  logic                 msg_done;

  // pick the child for the current bit, MSB first
  assign child     = byte_q[BYTE_W-1] ? ram_rdata_i[CHILD_W-1:0]
                                      : ram_rdata_i[2*CHILD_W-1:CHILD_W];
  assign child_neg = CHILD_W'(0) - child;
  assign child_pos = !child[CHILD_W-1] && (child != '0);
  assign leaf      = !(child_pos && (child[MAG_W-1:0] < NODE_LIMIT));
  assign sym       = child_pos ? '0 : child_neg[SYM_W-1:0];
  assign cnt_inc   = count_q + 1'b1;
  assign msg_done  = (count_q >= total_q);
  assign out_free  = !out_valid_q || m_tready_i;

  assign ram_waddr_o = AW'(q_cmd_i.node_index);
  assign ram_wdata_o = {q_cmd_i.zero_branch, q_cmd_i.one_branch};
  assign ram_raddr_o = node_d;

  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    count_d      = count_q;
    byte_d       = byte_q;
    bits_d       = bits_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_done_d  = pend_done_q;
    q_pop_o      = 1'b0;
    ram_we_o     = 1'b0;
    out_push     = 1'b0;
    out_last_n   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            KIND_LOAD: begin
              ram_we_o = 1'b1;
            end
            KIND_START: begin
              node_d  = '0;
              count_d = '0;
            end
            KIND_DECODE: begin
              byte_d  = q_cmd_i.data_byte;
              bits_d  = '0;
              state_d = ST_FETCH;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (msg_done) begin
          state_d = ST_FLUSH;
        end else if (!(leaf && pend_valid_q && !out_free)) begin
          byte_d = byte_q << 1;
          bits_d = bits_q + 1'b1;
          if (leaf) begin
            // a newer symbol exists, so the held one is not last of byte
            out_push     = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_sym_d   = sym;
            pend_done_d  = (cnt_inc == total_q);
            count_d      = cnt_inc;
            node_d       = '0;
          end else begin
            node_d = child[AW-1:0];
          end
          if (bits_q == BIT_CNT_W'(BYTE_W - 1)) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_push     = 1'b1;
          out_last_n   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_q       <= '0;
      count_q      <= '0;
      total_q      <= '0;
      bits_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_q       <= node_d;
      count_q      <= count_d;
      bits_q       <= bits_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    pend_sym_q  <= pend_sym_d;
    pend_done_q <= pend_done_d;
    if (out_push) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= out_last_n;
      out_done_q <= pend_done_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_symbol_o = out_sym_q;
  assign m_last_o   = out_last_q;
  assign m_done_o   = out_done_q;

endmodule

`default_nettype wire

>>> sv/huffman_tree_walk_decoder_core.sv
// Top level of the Huffman tree-walk decoder.
// Usage: requests arrive on the s_axis channel. tuser carries the opcode:
// load a tree node, decode one compressed byte, or start a new message.
// Load tree nodes first, write total_symbols through cfg_we_i/cfg_wdata_i,
// send a start request, then stream compressed bytes. Decoded symbols leave
// on m_axis, tlast marking the final symbol of a byte and tuser[0] the final
// symbol of the message.
// Occupancy: a decode request occupies the tree walker through a pop, one
// fetch of the current node, up to eight steps (fewer once the message is
// complete, and held while m_axis stalls) and a flush; load and start
// requests finish at the pop. The rate is set by the tree RAM: each step
// needs the registered read of the node chosen by the step before.
// Each symbol is held until the next one or the end of the byte decides
// its tlast, and is then registered onto m_axis.
// A two-entry queue separates intake from the walker, so s_axis keeps
// taking requests until full while the walker works or m_axis stalls. A
// stalled receiver freezes the walker at the next symbol; nothing is dropped.
// Reset clears the walk to the root, the symbol count and total_symbols;
// tree contents are kept undefined until loaded.
`default_nettype none

module huffman_tree_walk_decoder_core #(
  parameter int TREE_NODES  = htwd_pkg::TREE_NODES_DEF,
  parameter int QUEUE_DEPTH = htwd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // total_symbols register
  input  wire logic                             cfg_we_i,
  input  wire logic [htwd_pkg::CNT_W-1:0]       cfg_wdata_i,
  // requests
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // [6:0] node_index, [15:7] child for bit 0, [24:16] child for bit 1,
  // [32:25] data_byte, [39:33] zero
  input  wire logic [htwd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] op
  input  wire logic [htwd_pkg::OP_W-1:0]        s_axis_tuser,
  // decoded symbols
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [7:0] symbol
  output      logic [htwd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // last_of_byte
  output      logic                             m_axis_tlast,
  // [0] message_done
  output      logic [0:0]                       m_axis_tuser
);

  import htwd_pkg::*;

  localparam int AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;

  // front end to queue
  logic       fifo_push;
  logic       fifo_pop;
  logic       fifo_full;
  logic       fifo_empty;
  htwd_cmd_t  front_cmd;
  htwd_cmd_t  queue_cmd;

  // walker to tree RAM
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [2*CHILD_W-1:0]   ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [2*CHILD_W-1:0]   ram_rdata;

  logic [SYM_W-1:0]       out_symbol;
  logic                   out_done;

  htwd_front #(
    .TREE_NODES (TREE_NODES)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_full_i   (fifo_full),
    .q_push_o   (fifo_push),
    .q_cmd_o    (front_cmd)
  );

  htwd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (front_cmd),
    .pop_i   (fifo_pop),
    .rdata_o (queue_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // left and right child of every node share one word
  htwd_ram #(
    .WIDTH (2 * CHILD_W),
    .DEPTH (TREE_NODES),
    .AW    (AW)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  htwd_back #(
    .TREE_NODES (TREE_NODES),
    .AW         (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (fifo_empty),
    .q_cmd_i     (queue_cmd),
    .q_pop_o     (fifo_pop),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_symbol_o  (out_symbol),
    .m_last_o    (m_axis_tlast),
    .m_done_o    (out_done)
  );

  assign m_axis_tdata    = OUT_DATA_W'(out_symbol);
  assign m_axis_tuser[0] = out_done;

  // the front end never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_push && fifo_full))
    else $error("request pushed into full queue");

  // the walker only pops what is there
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_pop && fifo_empty))
    else $error("queue popped while empty");

  // tree writes come only from a load command taken off the queue
  a_write_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (fifo_pop && !fifo_empty))
    else $error("tree RAM written without a queued load");

endmodule

`default_nettype wire

>>> test/htwd_checker.sv
// Symbol predictor and scoreboard for the Huffman tree-walk decoder test.
`timescale 1ns / 1ps

module htwd_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [htwd_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [htwd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic [htwd_pkg::OP_W-1:0]           s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [htwd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                m_axis_tlast,
  input  logic [0:0]                          m_axis_tuser,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  requests_seen,
  output int                                  bytes_seen,
  output int                                  symbols_seen,
  output int                                  messages_seen
);

  import htwd_pkg::*;

  localparam int NODES    = TREE_NODES_DEF;
  localparam int LEFT_LO  = IDX_W;
  localparam int RIGHT_LO = LEFT_LO + CHILD_W;
  localparam int BYTE_LO  = RIGHT_LO + CHILD_W;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_byte;
    logic             message_done;
  } symbol_t;

  logic signed [CHILD_W-1:0] left_tab  [NODES];
  logic signed [CHILD_W-1:0] right_tab [NODES];
  logic [IDX_W-1:0]          walk_node;
  logic [CNT_W-1:0]          sym_count;
  logic [CNT_W-1:0]          total_syms;
  symbol_t                   awaited_syms[$];
  int fails, n_req, n_bytes, n_syms, n_msgs;

  // Walk one compressed byte, MSB first, and queue every symbol it yields.
  task automatic walk_byte(input logic [BYTE_W-1:0] dbyte);
    symbol_t held;
    bit      have;
    int      child;
    have = 1'b0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      if (sym_count >= total_syms) break;
      child = dbyte[b] ? int'(right_tab[walk_node]) : int'(left_tab[walk_node]);
      if (child > 0 && child < NODES) begin
        walk_node = IDX_W'(child);
      end else begin
        if (have) awaited_syms.insert(awaited_syms.size(), held);
        // a pointer past the table decodes as symbol zero
        held.symbol       = (child <= 0) ? SYM_W'(-child) : '0;
        sym_count         = sym_count + 1'b1;
        held.last_of_byte = 1'b0;
        held.message_done = (sym_count == total_syms);
        walk_node         = '0;
        have              = 1'b1;
      end
    end
    if (have) begin
      held.last_of_byte = 1'b1;
      awaited_syms.insert(awaited_syms.size(), held);
    end
  endtask

  task automatic check_symbol();
    symbol_t want;
    if (awaited_syms.size() == 0) begin
      fails++;
      $display("%0t: unexpected symbol: expected none, actual %h last %b done %b",
               $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end else begin
      want = awaited_syms.pop_front();
      n_syms++;
      if (m_axis_tuser[0]) n_msgs++;
      if (m_axis_tdata !== want.symbol) begin
        fails++;
        $display("%0t: symbol mismatch: expected %h, actual %h",
                 $time, want.symbol, m_axis_tdata);
      end
      if (m_axis_tlast !== want.last_of_byte) begin
        fails++;
        $display("%0t: last_of_byte mismatch: expected %b, actual %b",
                 $time, want.last_of_byte, m_axis_tlast);
      end
      if (m_axis_tuser[0] !== want.message_done) begin
        fails++;
        $display("%0t: message_done mismatch: expected %b, actual %b",
                 $time, want.message_done, m_axis_tuser[0]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_node  = '0;
      sym_count  = '0;
      total_syms = '0;
      awaited_syms.delete();
      fails   = 0;
      n_req   = 0;
      n_bytes = 0;
      n_syms  = 0;
      n_msgs  = 0;
    end else begin
      if (cfg_we_i) total_syms = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) check_symbol();
      if (s_axis_tvalid && s_axis_tready) begin
        n_req++;
        case (s_axis_tuser)
          OP_LOAD: begin
            left_tab[s_axis_tdata[IDX_W-1:0]]  = s_axis_tdata[LEFT_LO +: CHILD_W];
            right_tab[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[RIGHT_LO +: CHILD_W];
          end
          OP_DECODE: begin
            n_bytes++;
            walk_byte(s_axis_tdata[BYTE_LO +: BYTE_W]);
          end
          OP_START: begin
            walk_node = '0;
            sym_count = '0;
          end
          default: ;
        endcase
      end
    end
    fail_count    <= fails;
    pending       <= awaited_syms.size();
    requests_seen <= n_req;
    bytes_seen    <= n_bytes;
    symbols_seen  <= n_syms;
    messages_seen <= n_msgs;
  end

endmodule

>>> test/huffman_tree_walk_decoder_core_test.sv
// Stimulus and verdict for the Huffman tree-walk decoder core.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_core_test;
  import htwd_pkg::*;

  // op code that the block must ignore
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CNT_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic [0:0]            m_axis_tuser;

  int fail_count, pending, requests_seen, bytes_seen, symbols_seen, messages_seen;

  // Nodes loaded so far; pointers only ever name these, so the walk never
  // lands on an unwritten entry.
  bit node_written[TREE_NODES_DEF];
  bit calm_sender;
  bit calm_receiver;

  huffman_tree_walk_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  htwd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .requests_seen (requests_seen),
    .bytes_seen    (bytes_seen),
    .symbols_seen  (symbols_seen),
    .messages_seen (messages_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Present one request and hold it until the block takes it. Call on a
  // clock edge; return on the edge of the handshake with tvalid still high.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [CHILD_W-1:0] lc, input logic [CHILD_W-1:0] rc,
                              input logic [BYTE_W-1:0] dbyte);
    int gap;
    gap = calm_sender ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W - IDX_W - 2 * CHILD_W - BYTE_W){1'b0}}, dbyte, rc, lc, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_node(input logic [IDX_W-1:0] idx, input logic signed [CHILD_W-1:0] lc,
                           input logic signed [CHILD_W-1:0] rc);
    send_request(OP_LOAD, idx, lc, rc, BYTE_W'($urandom));
    node_written[idx] = 1'b1;
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] dbyte);
    send_request(OP_DECODE, IDX_W'($urandom), CHILD_W'($urandom), CHILD_W'($urandom), dbyte);
  endtask

  task automatic start_message();
    send_request(OP_START, IDX_W'($urandom), CHILD_W'($urandom), CHILD_W'($urandom),
                 BYTE_W'($urandom));
  endtask

  // Half leaves over the whole symbol range, half pointers to loaded nodes or to itself, else a leaf.
  function automatic logic signed [CHILD_W-1:0] draw_child(input int self);
    int leaf_sym;
    int j;
    leaf_sym = $urandom_range(0, 256);
    if ($urandom_range(0, 1) == 0) return CHILD_W'(-leaf_sym);
    for (int t = 0; t < 8; t++) begin
      j = $urandom_range(1, TREE_NODES_DEF - 1);
      if (node_written[j] || j == self) return CHILD_W'(j);
    end
    return CHILD_W'(-leaf_sym);
  endfunction

  task automatic load_random_node();
    int idx;
    idx = $urandom_range(0, TREE_NODES_DEF - 1);
    load_node(IDX_W'(idx), draw_child(idx), draw_child(idx));
  endtask

  // Drop tvalid, let every awaited symbol arrive, then give a byte that
  // yields nothing time to leave the walker.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: drop tready for a random gap before each symbol, unless calm_receiver is set.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = calm_receiver ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic [CNT_W-1:0] total;
    int n_loads;
    int n_bytes;
    int w;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    calm_sender   = 1'b0;
    calm_receiver = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tree: root left goes to node 1, root right is the extreme
    // negative leaf (symbol zero); node 1 holds symbol 255 and a pointer;
    // node 2 holds leaf zero and a pointer to the top node index.
    load_node(7'd127, -9'sd170, -9'sd85);
    load_node(7'd2, 9'sd0, 9'sd127);
    load_node(7'd1, -9'sd255, 9'sd2);
    load_node(7'd0, 9'sd1, -9'sd256);

    // Total of zero after reset: bytes decode nothing.
    decode_byte(8'hFF);
    // Unused op code changes nothing.
    send_request(OP_NONE, 7'h7F, 9'h1FF, 9'h1FF, 8'hFF);
    settle();

    // Widest message: never completes.
    write_total(20'hFFFFF);
    start_message();
    decode_byte(8'h00);
    decode_byte(8'hFF);
    decode_byte(8'h5A);
    decode_byte(8'hC3);
    // Reload a node in the middle of a message.
    load_node(7'd127, -9'sd1, -9'sd128);
    decode_byte(8'h7F);
    send_request(OP_NONE, 7'h00, 9'h000, 9'h000, 8'h00);
    decode_byte(8'hA5);
    settle();

    // Short message: stop mid-byte, ignore the rest, restart.
    write_total(20'd3);
    start_message();
    decode_byte(8'h00);
    decode_byte(8'hFF);
    start_message();
    decode_byte(8'hFF);
    settle();

    // Random messages over a growing random tree.
    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 9))
        0:       total = '0;
        1:       total = 20'd1;
        2, 3, 4, 5: total = CNT_W'($urandom_range(2, 40));
        6, 7:    total = CNT_W'($urandom_range(41, 120));
        8:       total = 20'hFFFFF;
        default: total = CNT_W'($urandom_range(0, 20'hFFFFF));
      endcase
      calm_sender   = ($urandom_range(0, 3) == 0);
      calm_receiver = ($urandom_range(0, 3) == 0);
      write_total(total);
      start_message();
      n_loads = (phase == 0) ? 12 : $urandom_range(1, 6);
      repeat (n_loads) load_random_node();
      n_bytes = $urandom_range(18, 30);
      repeat (n_bytes) begin
        case ($urandom_range(0, 19))
          0: send_request(OP_NONE, IDX_W'($urandom), CHILD_W'($urandom),
                          CHILD_W'($urandom), BYTE_W'($urandom));
          1: start_message();
          2: load_random_node();
          default: decode_byte(BYTE_W'($urandom));
        endcase
      end
      settle();
    end

    // Final drain, bounded so a lost symbol shows up as a failure.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    for (w = 0; w < 4000 && pending != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending != 0) $display("tb: %0d decoded symbols never arrived", pending);

    $display("tb: %0d requests, %0d compressed bytes, %0d symbols checked, %0d messages done",
             requests_seen, bytes_seen, symbols_seen, messages_seen);
    $display("tb: totals 0, 1, 3 and 1048575 plus random ones, with stalls on both channels");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
